// ===== rtl/ring_fifo_with_match_count_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ring FIFO core
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef RING_FIFO_WITH_MATCH_COUNT_CORE_DEFINES_SVH
`define RING_FIFO_WITH_MATCH_COUNT_CORE_DEFINES_SVH

// prop is a property expression, typically an implication
`define RFMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// expr must never be true at a clock edge
`define RFMC_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ===== rtl/rfmc_pkg.sv =====
// ----------------------------------------------------------------------------
// rfmc_pkg
// Types, codes and constants shared by the ring FIFO core modules.
// ----------------------------------------------------------------------------
package rfmc_pkg;

  localparam int MAX_DEPTH_DEF = 64;
  localparam int WORD_BITS_DEF = 32;

  localparam int DATA_W     = 32;
  localparam int COUNT_W    = 7;
  localparam int CAP_W      = 3;
  localparam int WCODE_W    = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CAP_W-1:0]     CAP_LOG2_RST   = 3'd6;
  localparam logic [WCODE_W-1:0]   WCODE_RST      = 2'd2;
  localparam logic [WCODE_W-1:0]   WCODE_1B       = 2'd0;
  localparam logic [WCODE_W-1:0]   WCODE_2B       = 2'd1;
  localparam logic [WCODE_W-1:0]   WCODE_4B       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAP_LOG2   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_CODE = 2'd1;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_FLUSH = 2'd2,
    ACT_COUNT = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    FILL_EMPTY  = 2'd0,
    FILL_NORMAL = 2'd1,
    FILL_FULL   = 2'd2
  } fill_e;

  typedef enum logic [2:0] {
    ST_EMPTY    = 3'd0,
    ST_NORMAL   = 3'd1,
    ST_FULL     = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_UNDERRUN = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP_WAIT,
    S_WALK
  } ctrl_state_e;

  typedef struct packed {
    action_e           action;
    logic [DATA_W-1:0] data_word;
  } in_t;

  typedef struct packed {
    status_e            status;
    logic [DATA_W-1:0]  read_data;
    logic [COUNT_W-1:0] match_count;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic ld_op;
    logic pop_rd;
    logic walk_init;
    logic walk_run;
    logic retire;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    action_e action;
    logic    fifo_empty;
    logic    walk_done;
    logic    slot_free;
  } dp_status_t;

  function automatic status_e fill_to_status(fill_e f);
    status_e s;
    unique case (f)
      FILL_EMPTY:  s = ST_EMPTY;
      FILL_NORMAL: s = ST_NORMAL;
      FILL_FULL:   s = ST_FULL;
      default:     s = ST_EMPTY;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/rfmc_ram.sv =====
// ----------------------------------------------------------------------------
// rfmc_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rfmc_ram #(
  parameter int WIDTH = rfmc_pkg::WORD_BITS_DEF,
  parameter int DEPTH = rfmc_pkg::MAX_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/rfmc_ctrl.sv =====
// ----------------------------------------------------------------------------
// rfmc_ctrl
// Sequencer: accepts requests, steps pop reads and count walks, retires.
// ----------------------------------------------------------------------------
module rfmc_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  rfmc_pkg::dp_status_t   status_i,
  output rfmc_pkg::dp_cmd_t      cmd_o
);

  rfmc_pkg::ctrl_state_e state_q, state_d;
  logic                  accept_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rfmc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    unique case (state_q)
      rfmc_pkg::S_IDLE: begin
      end
      rfmc_pkg::S_EXEC: begin
        unique case (status_i.action) inside
          rfmc_pkg::ACT_PUSH, rfmc_pkg::ACT_FLUSH: begin
            cmd_o.retire = status_i.slot_free;
          end
          rfmc_pkg::ACT_POP: begin
            // underrun needs no read
            if (status_i.fifo_empty) begin
              cmd_o.retire = status_i.slot_free;
            end else begin
              cmd_o.pop_rd = 1'b1;
              state_d      = rfmc_pkg::S_POP_WAIT;
            end
          end
          rfmc_pkg::ACT_COUNT: begin
            cmd_o.walk_init = 1'b1;
            state_d         = rfmc_pkg::S_WALK;
          end
          default: begin
          end
        endcase
      end
      rfmc_pkg::S_POP_WAIT: begin
        cmd_o.retire = status_i.slot_free;
      end
      rfmc_pkg::S_WALK: begin
        cmd_o.walk_run = 1'b1;
        cmd_o.retire   = status_i.walk_done && status_i.slot_free;
      end
      default: begin
        state_d = rfmc_pkg::S_IDLE;
      end
    endcase

    // a retiring request frees the operand register for the next one
    accept_ok    = (state_q == rfmc_pkg::S_IDLE) || cmd_o.retire;
    cmd_o.ld_op  = accept_ok && in_valid_i;
    if (cmd_o.retire) begin
      state_d = rfmc_pkg::S_IDLE;
    end
    if (cmd_o.ld_op) begin
      state_d = rfmc_pkg::S_EXEC;
    end
  end

  assign in_stall_o = !accept_ok;

endmodule

// ===== rtl/rfmc_dp.sv =====
// ----------------------------------------------------------------------------
// rfmc_dp
// FIFO datapath: config registers, indices, entry RAM, walk counters, output.
// ----------------------------------------------------------------------------
module rfmc_dp #(
  parameter int MAX_DEPTH = rfmc_pkg::MAX_DEPTH_DEF,
  parameter int WORD_BITS = rfmc_pkg::WORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rfmc_pkg::in_t                     in_data_i,
  input  logic                              cfg_valid_i,
  input  logic [rfmc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [rfmc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              out_stall_i,
  input  rfmc_pkg::dp_cmd_t                 cmd_i,
  output rfmc_pkg::dp_status_t              status_o,
  output logic                              out_valid_o,
  output rfmc_pkg::out_t                    out_data_o
);

  // largest power of two not above MAX_DEPTH
  localparam int LOG_MAX   = $clog2(MAX_DEPTH + 1) - 1;
  localparam int IW        = LOG_MAX;
  localparam int CW        = LOG_MAX + 1;
  localparam int RAM_DEPTH = 1 << LOG_MAX;
  localparam int WB_W      = $clog2(WORD_BITS + 1);

  logic [rfmc_pkg::CAP_W-1:0]   cap_log2_q, cap_log2_d;
  logic [rfmc_pkg::WCODE_W-1:0] wcode_q, wcode_d;
  logic [IW-1:0]                wi_q, wi_d, ri_q, ri_d;
  rfmc_pkg::fill_e              fill_q, fill_d;
  rfmc_pkg::action_e            act_q;
  logic [WORD_BITS-1:0]         word_q;
  logic [IW-1:0]                walk_idx_q, walk_idx_d;
  logic [CW-1:0]                remain_q, remain_d;
  logic                         pend_q, pend_d;
  logic [CW-1:0]                cnt_q, cnt_d;
  logic                         out_valid_q, out_valid_d;
  rfmc_pkg::out_t               out_q, out_d;

  logic [rfmc_pkg::CAP_W-1:0]   lg_eff;
  logic [IW-1:0]                imask;
  logic [WB_W-1:0]              ent_bits;
  logic [WORD_BITS-1:0]         wmask;
  logic [IW-1:0]                wi_inc, ri_inc, walk_inc;
  logic [CW-1:0]                walk_len;
  logic [WORD_BITS-1:0]         rd_word;
  logic                         cfg_hit;
  logic                         remain_nz;

  logic                         ram_we, ram_re;
  logic [IW-1:0]                ram_raddr;
  logic [WORD_BITS-1:0]         ram_rdata;

  // effective capacity and entry width
  always_comb begin
    lg_eff = cap_log2_q;
    if (cap_log2_q == '0) begin
      lg_eff = rfmc_pkg::CAP_W'(1);
    end else if (int'(cap_log2_q) > LOG_MAX) begin
      lg_eff = rfmc_pkg::CAP_W'(LOG_MAX);
    end
    for (int b = 0; b < IW; b++) begin
      imask[b] = (b < int'(lg_eff));
    end

    ent_bits = WB_W'(WORD_BITS);
    unique case (wcode_q)
      rfmc_pkg::WCODE_1B: if (WORD_BITS > 8)  ent_bits = WB_W'(8);
      rfmc_pkg::WCODE_2B: if (WORD_BITS > 16) ent_bits = WB_W'(16);
      default:            ent_bits = WB_W'(WORD_BITS);
    endcase
    for (int b = 0; b < WORD_BITS; b++) begin
      wmask[b] = (b < int'(ent_bits));
    end
  end

  assign wi_inc   = IW'(wi_q + 1'b1) & imask;
  assign ri_inc   = IW'(ri_q + 1'b1) & imask;
  assign walk_inc = IW'(walk_idx_q + 1'b1) & imask;
  assign rd_word  = ram_rdata & wmask;
  assign remain_nz = |remain_q;
  assign cfg_hit  = cfg_valid_i && (cfg_index_i == rfmc_pkg::CFG_CAP_LOG2 ||
                                    cfg_index_i == rfmc_pkg::CFG_WIDTH_CODE);

  always_comb begin
    unique case (fill_q)
      rfmc_pkg::FILL_EMPTY: walk_len = '0;
      rfmc_pkg::FILL_FULL:  walk_len = CW'({1'b0, imask}) + 1'b1;
      default:              walk_len = CW'(IW'(wi_q - ri_q) & imask);
    endcase
  end

  // commit of the current request at retire, and config register writes
  always_comb begin
    cap_log2_d  = cap_log2_q;
    wcode_d     = wcode_q;
    wi_d        = wi_q;
    ri_d        = ri_q;
    fill_d      = fill_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    ram_we      = 1'b0;

    if (cmd_i.retire) begin
      out_valid_d       = 1'b1;
      out_d.status      = rfmc_pkg::fill_to_status(fill_q);
      out_d.read_data   = '0;
      out_d.match_count = '0;
      unique case (act_q)
        rfmc_pkg::ACT_PUSH: begin
          if (fill_q == rfmc_pkg::FILL_FULL) begin
            out_d.status = rfmc_pkg::ST_OVERFLOW;
          end else begin
            ram_we       = 1'b1;
            wi_d         = wi_inc;
            fill_d       = (wi_inc == ri_q) ? rfmc_pkg::FILL_FULL : rfmc_pkg::FILL_NORMAL;
            out_d.status = rfmc_pkg::fill_to_status(fill_d);
          end
        end
        rfmc_pkg::ACT_POP: begin
          if (fill_q == rfmc_pkg::FILL_EMPTY) begin
            out_d.status = rfmc_pkg::ST_UNDERRUN;
          end else begin
            out_d.read_data = rfmc_pkg::DATA_W'(rd_word);
            ri_d            = ri_inc;
            fill_d          = (ri_inc == wi_q) ? rfmc_pkg::FILL_EMPTY
                                               : rfmc_pkg::FILL_NORMAL;
            out_d.status    = rfmc_pkg::fill_to_status(fill_d);
          end
        end
        rfmc_pkg::ACT_FLUSH: begin
          wi_d         = ri_q;
          fill_d       = rfmc_pkg::FILL_EMPTY;
          out_d.status = rfmc_pkg::ST_EMPTY;
        end
        rfmc_pkg::ACT_COUNT: begin
          out_d.match_count = rfmc_pkg::COUNT_W'(cnt_q);
        end
        default: begin
        end
      endcase
    end

    // any register write re-initializes the FIFO
    if (cfg_hit) begin
      wi_d   = '0;
      ri_d   = '0;
      fill_d = rfmc_pkg::FILL_EMPTY;
      if (cfg_index_i == rfmc_pkg::CFG_CAP_LOG2) begin
        cap_log2_d = cfg_data_i[rfmc_pkg::CAP_W-1:0];
      end else begin
        wcode_d = cfg_data_i[rfmc_pkg::WCODE_W-1:0];
      end
    end
  end

  // count walk: one read issued per cycle, compared in the next cycle
  always_comb begin
    walk_idx_d = walk_idx_q;
    remain_d   = remain_q;
    pend_d     = pend_q;
    cnt_d      = cnt_q;
    ram_re     = 1'b0;
    ram_raddr  = walk_idx_q;

    if (cmd_i.walk_init) begin
      walk_idx_d = ri_q;
      remain_d   = walk_len;
      pend_d     = 1'b0;
      cnt_d      = '0;
    end else if (cmd_i.walk_run) begin
      pend_d = remain_nz;
      if (remain_nz) begin
        ram_re     = 1'b1;
        walk_idx_d = walk_inc;
        remain_d   = remain_q - 1'b1;
      end
      if (pend_q && (rd_word == word_q)) begin
        cnt_d = cnt_q + 1'b1;
      end
    end

    if (cmd_i.pop_rd) begin
      ram_re    = 1'b1;
      ram_raddr = ri_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_log2_q  <= rfmc_pkg::CAP_LOG2_RST;
      wcode_q     <= rfmc_pkg::WCODE_RST;
      wi_q        <= '0;
      ri_q        <= '0;
      fill_q      <= rfmc_pkg::FILL_EMPTY;
      remain_q    <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cap_log2_q  <= cap_log2_d;
      wcode_q     <= wcode_d;
      wi_q        <= wi_d;
      ri_q        <= ri_d;
      fill_q      <= fill_d;
      remain_q    <= remain_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_op) begin
      act_q  <= in_data_i.action;
      word_q <= in_data_i.data_word[WORD_BITS-1:0] & wmask;
    end
    walk_idx_q <= walk_idx_d;
    cnt_q      <= cnt_d;
    out_q      <= out_d;
  end

  rfmc_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wi_q),
    .wdata_i (word_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign status_o.action     = act_q;
  assign status_o.fifo_empty = (fill_q == rfmc_pkg::FILL_EMPTY);
  assign status_o.walk_done  = !remain_nz && !pend_q;
  assign status_o.slot_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/ring_fifo_with_match_count_core.sv =====
// ----------------------------------------------------------------------------
// ring_fifo_with_match_count_core
// Circular FIFO with push, pop, flush and count-matching-entries requests.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o / in_data_i) carries one request:
// action and data_word. Output channel (out_valid_o / out_stall_i /
// out_data_o) returns exactly one result per request: status, read_data,
// match_count. Config channel (cfg_valid_i / cfg_ready_o) writes
// capacity_log2 (index 0) or entry_width_code (index 1); either write
// empties the FIFO. Write config only while no request is in flight.
// Push, flush and underrun pop retire from the execute state; a pop reads the
// entry RAM and a count walks the stored entries (one entry per cycle on the
// RAM's single read port) first. Push/flush take 1 request per cycle while
// the output is not stalled; a pop read or count walk holds off the next
// request until it retires. A finished result waits in the output register
// while the next request is accepted; a stall on the output holds that request
// at retire and then stalls the input. Reset (async, active low) empties the
// FIFO, sets capacity 64 and four-byte entries; the entry RAM is not cleared.
// ----------------------------------------------------------------------------
`include "ring_fifo_with_match_count_core_defines.svh"

module ring_fifo_with_match_count_core #(
  parameter int MAX_DEPTH = rfmc_pkg::MAX_DEPTH_DEF,
  parameter int WORD_BITS = rfmc_pkg::WORD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  rfmc_pkg::in_t                   in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output rfmc_pkg::out_t                  out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rfmc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [rfmc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  rfmc_pkg::dp_cmd_t    cmd;
  rfmc_pkg::dp_status_t dp_status;

  assign cfg_ready_o = 1'b1;

  rfmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  rfmc_dp #(
    .MAX_DEPTH (MAX_DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .status_o    (dp_status),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  `RFMC_ASSERT(a_out_from_retire, $rose(out_valid_o) |-> $past(cmd.retire), "result without retire")
  `RFMC_ASSERT(a_walk_blocks_in, (cmd.walk_run && !dp_status.walk_done) |-> in_stall_o, "request accepted during walk")
  `RFMC_ASSERT(a_retire_no_overwrite, (cmd.retire && out_valid_o) |-> !out_stall_i, "result overwritten while stalled")
  `RFMC_ASSERT_NEVER(a_read_vs_retire, (cmd.pop_rd || cmd.walk_init) && cmd.retire, "read issued while retiring")

endmodule

// ===== tb/sv/ring_fifo_with_match_count_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ring_fifo_with_match_count_core_tb
// Self-checking bench for the ring FIFO core. A directed run covers the
// empty, full, overflow, underrun, flush and wrapped-count cases. It is
// followed by randomized phases over several capacity and entry-width
// settings, with random gaps on the request side and random stalls on the
// result side. Results are checked in order against a cycle-free FIFO model.
// ----------------------------------------------------------------------------
module ring_fifo_with_match_count_core_tb;

  localparam int IDLE_LIMIT = 4000;

  // --------------------------------------------------------------------------
  // FIFO model and result queue
  class fifo_scoreboard;
    logic [rfmc_pkg::DATA_W-1:0]  entries [rfmc_pkg::MAX_DEPTH_DEF];
    int unsigned                  wr_ptr;
    int unsigned                  rd_ptr;
    rfmc_pkg::status_e            fill;
    logic [rfmc_pkg::CAP_W-1:0]   cap_log2;
    logic [rfmc_pkg::WCODE_W-1:0] width_code;
    rfmc_pkg::out_t               pending_results [$];
    int                           mismatches;

    function new();
      foreach (entries[i]) entries[i] = '0;
      cap_log2   = rfmc_pkg::CAP_LOG2_RST;
      width_code = rfmc_pkg::WCODE_RST;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      wr_ptr = 0;
      rd_ptr = 0;
      fill   = rfmc_pkg::ST_EMPTY;
    endfunction

    function void apply_config(logic [rfmc_pkg::CFG_IDX_W-1:0] idx,
                               logic [rfmc_pkg::CFG_DATA_W-1:0] val);
      if (idx == rfmc_pkg::CFG_CAP_LOG2) begin
        cap_log2 = val[rfmc_pkg::CAP_W-1:0];
        restart();
      end else if (idx == rfmc_pkg::CFG_WIDTH_CODE) begin
        width_code = val[rfmc_pkg::WCODE_W-1:0];
        restart();
      end
    endfunction

    function int unsigned capacity();
      int unsigned lg;
      int unsigned cap;
      lg = cap_log2;
      if (lg < 1) lg = 1;
      if (lg > 7) lg = 7;
      cap = 1 << lg;
      while (cap > rfmc_pkg::MAX_DEPTH_DEF && cap > 1) cap = cap >> 1;
      return cap;
    endfunction

    function logic [rfmc_pkg::DATA_W-1:0] width_mask();
      int unsigned code;
      int unsigned bits;
      code = width_code;
      if (code > rfmc_pkg::WCODE_4B) code = rfmc_pkg::WCODE_4B;
      bits = 8 << code;
      if (bits > rfmc_pkg::WORD_BITS_DEF) bits = rfmc_pkg::WORD_BITS_DEF;
      if (bits >= 32) return '1;
      return (32'd1 << bits) - 32'd1;
    endfunction

    function void note_request(rfmc_pkg::in_t req);
      rfmc_pkg::out_t              res;
      logic [rfmc_pkg::DATA_W-1:0] mask;
      logic [rfmc_pkg::DATA_W-1:0] word;
      int unsigned                 cap;
      int unsigned                 imask;
      int unsigned                 n;
      int unsigned                 idx;
      int unsigned                 hits;
      mask  = width_mask();
      word  = req.data_word & mask;
      cap   = capacity();
      imask = cap - 1;
      hits  = 0;
      res   = '0;
      res.status = fill;
      wr_ptr = wr_ptr & imask;
      rd_ptr = rd_ptr & imask;
      case (req.action)
        rfmc_pkg::ACT_PUSH: begin
          if (fill == rfmc_pkg::ST_FULL) begin
            res.status = rfmc_pkg::ST_OVERFLOW;
          end else begin
            entries[wr_ptr % rfmc_pkg::MAX_DEPTH_DEF] = word;
            wr_ptr = (wr_ptr + 1) & imask;
            fill = (wr_ptr == rd_ptr) ? rfmc_pkg::ST_FULL : rfmc_pkg::ST_NORMAL;
            res.status = fill;
          end
        end
        rfmc_pkg::ACT_POP: begin
          if (fill == rfmc_pkg::ST_EMPTY) begin
            res.status = rfmc_pkg::ST_UNDERRUN;
          end else begin
            res.read_data = entries[rd_ptr % rfmc_pkg::MAX_DEPTH_DEF] & mask;
            rd_ptr = (rd_ptr + 1) & imask;
            fill = (rd_ptr == wr_ptr) ? rfmc_pkg::ST_EMPTY : rfmc_pkg::ST_NORMAL;
            res.status = fill;
          end
        end
        rfmc_pkg::ACT_FLUSH: begin
          wr_ptr = rd_ptr;
          fill = rfmc_pkg::ST_EMPTY;
          res.status = rfmc_pkg::ST_EMPTY;
        end
        default: begin
          if (fill == rfmc_pkg::ST_EMPTY) n = 0;
          else if (fill == rfmc_pkg::ST_FULL) n = cap;
          else n = (wr_ptr - rd_ptr) & imask;
          idx = rd_ptr;
          // walk oldest to newest, wrapping at capacity
          for (int k = 0; k < n; k++) begin
            if ((entries[idx % rfmc_pkg::MAX_DEPTH_DEF] & mask) == word) hits++;
            idx = (idx + 1) & imask;
          end
          res.match_count = hits[rfmc_pkg::COUNT_W-1:0];
        end
      endcase
      pending_results.push_back(res);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    function void check_result(rfmc_pkg::out_t got);
      rfmc_pkg::out_t want;
      if (pending_results.size() == 0) begin
        flag($sformatf("result with none pending: status %0d data %h count %0d",
                       got.status, got.read_data, got.match_count));
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status || got.read_data !== want.read_data ||
          got.match_count !== want.match_count)
        flag($sformatf("mismatch: exp status %0d data %h count %0d, got %0d %h %0d",
                       want.status, want.read_data, want.match_count,
                       got.status, got.read_data, got.match_count));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            in_valid_i  = 1'b0;
  logic                            in_stall_o;
  rfmc_pkg::in_t                   in_data_i   = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  rfmc_pkg::out_t                  out_data_o;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [rfmc_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [rfmc_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;

  fifo_scoreboard               board;
  logic                         calm = 1'b0;
  logic [rfmc_pkg::WCODE_W-1:0] cur_width = rfmc_pkg::WCODE_RST;
  int                           idle_cycles = 0;

  ring_fifo_with_match_count_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 34);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_result(out_data_o);
  end

  // stall watchdog: cycles with no handshake on any channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int g;
    g = 0;
    if (calm) return 0;
    while ($urandom_range(99) < 34 && g < 20) g++;
    return g;
  endfunction

  function automatic rfmc_pkg::in_t make_req(rfmc_pkg::action_e act,
                                             logic [rfmc_pkg::DATA_W-1:0] word);
    rfmc_pkg::in_t r;
    r.action    = act;
    r.data_word = word;
    return r;
  endfunction

  // fill, drain or mixed bias; low bits often from a small pool so counts hit
  function automatic rfmc_pkg::in_t random_req(int mode);
    logic [rfmc_pkg::DATA_W-1:0] mask;
    logic [rfmc_pkg::DATA_W-1:0] low;
    int                          r;
    int                          push_lim;
    rfmc_pkg::action_e           act;
    case (cur_width)
      rfmc_pkg::WCODE_1B: mask = 32'h0000_00ff;
      rfmc_pkg::WCODE_2B: mask = 32'h0000_ffff;
      default:            mask = 32'hffff_ffff;
    endcase
    case ($urandom_range(3))
      0:       low = '0;
      1:       low = '1;
      2:       low = $urandom_range(3);
      default: low = $urandom;
    endcase
    push_lim = (mode == 0) ? 60 : (mode == 1) ? 15 : 40;
    r = $urandom_range(99);
    if (r < push_lim) act = rfmc_pkg::ACT_PUSH;
    else if (r < 75)  act = rfmc_pkg::ACT_POP;
    else if (r < 95)  act = rfmc_pkg::ACT_COUNT;
    else              act = rfmc_pkg::ACT_FLUSH;
    return make_req(act, ($urandom & ~mask) | (low & mask));
  endfunction

  task automatic send_request(rfmc_pkg::in_t req);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    board.note_request(req);
  endtask

  task automatic drain_requests();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_config(logic [rfmc_pkg::CFG_IDX_W-1:0] idx,
                              logic [rfmc_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    board.apply_config(idx, val);
    if (idx == rfmc_pkg::CFG_WIDTH_CODE) cur_width = val[rfmc_pkg::WCODE_W-1:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  initial begin
    logic [rfmc_pkg::CFG_DATA_W-1:0] cap;
    logic [rfmc_pkg::CFG_DATA_W-1:0] wcode;
    int                              mode;
    int                              run;
    board = new();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: 64 entries, four bytes
    send_request(make_req(rfmc_pkg::ACT_POP,   32'h0));
    send_request(make_req(rfmc_pkg::ACT_COUNT, 32'h0));
    send_request(make_req(rfmc_pkg::ACT_FLUSH, 32'hffff_ffff));
    send_request(make_req(rfmc_pkg::ACT_PUSH,  32'h0));
    send_request(make_req(rfmc_pkg::ACT_PUSH,  32'hffff_ffff));
    send_request(make_req(rfmc_pkg::ACT_PUSH,  32'h0));
    send_request(make_req(rfmc_pkg::ACT_COUNT, 32'h0));
    send_request(make_req(rfmc_pkg::ACT_COUNT, 32'hffff_ffff));
    send_request(make_req(rfmc_pkg::ACT_POP,   32'h0));
    send_request(make_req(rfmc_pkg::ACT_FLUSH, 32'h0));
    send_request(make_req(rfmc_pkg::ACT_POP,   32'h0));

    // two one-byte entries: full, overflow, wrapped count
    drain_requests();
    write_config(rfmc_pkg::CFG_CAP_LOG2, 8'd1);
    write_config(rfmc_pkg::CFG_WIDTH_CODE, 8'd0);
    send_request(make_req(rfmc_pkg::ACT_PUSH,  32'h1234_56ff));
    send_request(make_req(rfmc_pkg::ACT_PUSH,  32'h0000_00ab));
    send_request(make_req(rfmc_pkg::ACT_PUSH,  32'h0000_0011));
    send_request(make_req(rfmc_pkg::ACT_COUNT, 32'h7777_77ff));
    send_request(make_req(rfmc_pkg::ACT_POP,   32'h0));
    send_request(make_req(rfmc_pkg::ACT_PUSH,  32'hffff_ffff));
    send_request(make_req(rfmc_pkg::ACT_COUNT, 32'h0000_00ff));
    send_request(make_req(rfmc_pkg::ACT_POP,   32'h0));
    send_request(make_req(rfmc_pkg::ACT_POP,   32'h0));
    send_request(make_req(rfmc_pkg::ACT_POP,   32'h0));
    send_request(make_req(rfmc_pkg::ACT_COUNT, 32'h0));

    drain_requests();
    write_config(rfmc_pkg::CFG_WIDTH_CODE, 8'd1);
    send_request(make_req(rfmc_pkg::ACT_PUSH, 32'hffff_8001));
    send_request(make_req(rfmc_pkg::ACT_POP,  32'h0));

    for (int ph = 0; ph < 14; ph++) begin
      case (ph)
        0: begin cap = 8'd1; wcode = 8'd0; end
        1: begin cap = 8'd6; wcode = 8'd2; end
        2: begin cap = 8'd6; wcode = 8'd0; end
        3: begin cap = 8'd1; wcode = 8'd2; end
        default: begin
          cap   = ($urandom_range(3) == 0) ?
                  rfmc_pkg::CFG_DATA_W'($urandom_range(4, 6)) :
                  rfmc_pkg::CFG_DATA_W'($urandom_range(1, 3));
          wcode = rfmc_pkg::CFG_DATA_W'($urandom_range(2));
        end
      endcase
      drain_requests();
      calm = (ph == 5);
      write_config(rfmc_pkg::CFG_CAP_LOG2, cap);
      write_config(rfmc_pkg::CFG_WIDTH_CODE, wcode);
      run = 0;
      mode = 2;
      for (int k = 0; k < 130; k++) begin
        if (k == 65) drain_requests();
        if (run == 0) begin
          mode = $urandom_range(2);
          run  = $urandom_range(8, 30);
        end
        run--;
        send_request(random_req(mode));
      end
    end
    calm = 1'b0;

    drain_requests();
    repeat (20) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/rfmc_pkg.sv
rtl/rfmc_ram.sv
rtl/rfmc_ctrl.sv
rtl/rfmc_dp.sv
rtl/ring_fifo_with_match_count_core.sv
tb/sv/ring_fifo_with_match_count_core_tb.sv
